// ----- rtl/pfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

	// command codes
	localparam logic [2:0] CMD_INIT   = 3'd0;
	localparam logic [2:0] CMD_ALLOC  = 3'd1;
	localparam logic [2:0] CMD_FREE   = 3'd2;
	localparam logic [2:0] CMD_WIRE   = 3'd3;
	localparam logic [2:0] CMD_UNWIRE = 3'd4;

	// status codes
	localparam logic [2:0] STS_OK        = 3'd0;
	localparam logic [2:0] STS_NO_FREE   = 3'd1;
	localparam logic [2:0] STS_IS_FREE   = 3'd2;
	localparam logic [2:0] STS_IS_WIRED  = 3'd3;
	localparam logic [2:0] STS_NOT_WIRED = 3'd4;
	localparam logic [2:0] STS_WIRE_FULL = 3'd5;

	// per-page state codes
	typedef logic [1:0] page_st_t;
	localparam page_st_t PS_FREE  = 2'd0;
	localparam page_st_t PS_ALLOC = 2'd1;
	localparam page_st_t PS_WIRED = 2'd2;

	// register index, taken from paddr[2]
	localparam logic REG_FIRST_FREE = 1'b0;

	localparam int FIELD_W = 12;
	localparam int COUNT_W = 13;

endpackage

`default_nettype wire

// ----- rtl/page_frame_allocator_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Physical page frame allocator with a first-in first-out free list.
// Commands enter on start/command/page_index and are taken when start is high
// and busy is low. Each command gives exactly one result, shown for one cycle
// with done high, on status, allocated_page and the three page counters.
// Alloc, free, wire, unwire and unknown codes read the page memory (or the
// free ring at its head) when taken, then modify and write it back in the
// EXEC state. The result appears in the cycle after that, when busy is
// already low again, so a new command can be taken while done is high.
// Init walks every page once, writing each page entry, and a ring slot for
// each page at or beyond first_free_page; init with first_free_page at or
// beyond NUM_PAGES answers "no free page" and changes nothing.
// The receiver cannot stall; results are never held.
// The user must write first_free_page over APB only while idle; not enforced.
// Reset clears the counters, ring pointers and first_free_page; the page and
// ring memories hold nothing meaningful until the first init.

module page_frame_allocator_unit #(
	parameter int NUM_PAGES       = 4096,
	parameter int WIRE_COUNT_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// command channel
	input  wire logic        start,
	output logic             busy,
	input  wire logic [2:0]  command,
	input  wire logic [pfa_pkg::FIELD_W-1:0] page_index,
	// result channel
	output logic             done,
	output logic [2:0]       status,
	output logic [pfa_pkg::FIELD_W-1:0] allocated_page,
	output logic [pfa_pkg::COUNT_W-1:0] free_pages,
	output logic [pfa_pkg::COUNT_W-1:0] wired_pages,
	output logic [pfa_pkg::COUNT_W-1:0] allocated_pages,
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	import pfa_pkg::*;

	localparam int AW  = (NUM_PAGES > 1) ? $clog2(NUM_PAGES) : 1;
	localparam int CW  = $clog2(NUM_PAGES + 1);
	localparam int WCB = WIRE_COUNT_BITS;
	localparam int MW  = 2 + WCB;

	localparam logic [WCB-1:0] WC_ONE = WCB'(1);
	localparam logic [WCB-1:0] WC_MAX = {WCB{1'b1}};
	localparam logic [AW-1:0]  LAST_PAGE = AW'(NUM_PAGES - 1);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_EXEC  = 3'b010,
		ST_SWEEP = 3'b100
	} fsm_t;

	fsm_t state_q, state_d;

	logic [COUNT_W-1:0] ffp_q;
	logic [2:0]         cmd_q;
	logic [FIELD_W-1:0] pg_q;
	logic [AW-1:0]      sweep_q;

	logic [AW-1:0] head_q, head_d, tail_q, tail_d;
	logic [CW-1:0] free_cnt_q, free_cnt_d;
	logic [CW-1:0] wired_cnt_q, wired_cnt_d;
	logic [CW-1:0] alloc_cnt_q, alloc_cnt_d;

	logic               done_q, done_d;
	logic [2:0]         status_q, status_d;
	logic [AW-1:0]      given_q, given_d;

	// memory ports
	logic          meta_we, ring_we;
	logic [AW-1:0] meta_waddr, ring_waddr, meta_raddr;
	logic [MW-1:0] meta_wdata, meta_rdata;
	logic [AW-1:0] ring_wdata, ring_rdata;

	logic          accept;
	logic [31:0]   ffp32;
	logic [31:0]   room32;
	logic [31:0]   sweep_off;
	logic          sweep_wired;
	logic          pg_valid;
	logic [AW-1:0] pg_addr;
	page_st_t      ps_rd;
	logic [WCB-1:0] wc_rd, wc_dec;
	logic [AW-1:0] given_raw;

	function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
		ring_next = (p == LAST_PAGE) ? '0 : AW'(p + 1'b1);
	endfunction

	assign accept     = start && (state_q == ST_IDLE);
	assign busy       = (state_q != ST_IDLE);
	assign ffp32      = 32'(ffp_q);
	assign room32     = 32'(NUM_PAGES) - ffp32;
	assign sweep_off  = 32'(sweep_q) - ffp32;
	assign sweep_wired = 32'(sweep_q) < ffp32;
	assign pg_valid   = 32'(pg_q) < 32'(NUM_PAGES);
	assign pg_addr    = AW'(pg_q);
	assign ps_rd      = pg_valid ? page_st_t'(meta_rdata[MW-1 -: 2]) : PS_FREE;
	assign wc_rd      = meta_rdata[WCB-1:0];
	assign wc_dec     = wc_rd - WC_ONE;
	assign given_raw  = (32'(ring_rdata) >= 32'(NUM_PAGES)) ? '0 : ring_rdata;
	assign meta_raddr = AW'(page_index);

	// configuration port
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_FIRST_FREE) ? 32'(ffp_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ffp_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_FIRST_FREE) begin
			ffp_q <= pwdata[COUNT_W-1:0];
		end
	end

	always_comb begin
		state_d     = state_q;
		head_d      = head_q;
		tail_d      = tail_q;
		free_cnt_d  = free_cnt_q;
		wired_cnt_d = wired_cnt_q;
		alloc_cnt_d = alloc_cnt_q;
		done_d      = 1'b0;
		status_d    = status_q;
		given_d     = given_q;
		meta_we     = 1'b0;
		meta_waddr  = pg_addr;
		meta_wdata  = meta_rdata;
		ring_we     = 1'b0;
		ring_waddr  = tail_q;
		ring_wdata  = pg_addr;

		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (command == CMD_INIT && ffp32 < 32'(NUM_PAGES)) begin
						state_d = ST_SWEEP;
					end else begin
						state_d = ST_EXEC;
					end
				end
			end

			ST_SWEEP: begin
				meta_we    = 1'b1;
				meta_waddr = sweep_q;
				meta_wdata = sweep_wired ? {PS_WIRED, WC_ONE} : {PS_FREE, {WCB{1'b0}}};
				ring_we    = !sweep_wired;
				ring_waddr = sweep_off[AW-1:0];
				ring_wdata = sweep_q;
				if (sweep_q == LAST_PAGE) begin
					state_d     = ST_IDLE;
					head_d      = '0;
					tail_d      = (ffp_q == '0) ? '0 : room32[AW-1:0];
					free_cnt_d  = room32[CW-1:0];
					wired_cnt_d = ffp32[CW-1:0];
					alloc_cnt_d = '0;
					done_d      = 1'b1;
					status_d    = STS_OK;
					given_d     = '0;
				end
			end

			ST_EXEC: begin
				state_d  = ST_IDLE;
				done_d   = 1'b1;
				status_d = STS_OK;
				given_d  = '0;
				case (cmd_q)
					CMD_INIT: begin
						// only reached when no page would be left free
						status_d = STS_NO_FREE;
					end
					CMD_ALLOC: begin
						if (free_cnt_q == '0) begin
							status_d = STS_NO_FREE;
						end else begin
							// pages on the ring always carry a zero wire count
							given_d     = given_raw;
							meta_we     = 1'b1;
							meta_waddr  = given_raw;
							meta_wdata  = {PS_ALLOC, {WCB{1'b0}}};
							head_d      = ring_next(head_q);
							free_cnt_d  = free_cnt_q - 1'b1;
							alloc_cnt_d = alloc_cnt_q + 1'b1;
						end
					end
					CMD_FREE: begin
						if (ps_rd == PS_FREE) begin
							status_d = STS_IS_FREE;
						end else if (ps_rd != PS_ALLOC || wc_rd != '0
								|| free_cnt_q >= CW'(NUM_PAGES)) begin
							status_d = STS_IS_WIRED;
						end else begin
							meta_we     = 1'b1;
							meta_wdata  = {PS_FREE, wc_rd};
							ring_we     = 1'b1;
							tail_d      = ring_next(tail_q);
							free_cnt_d  = free_cnt_q + 1'b1;
							alloc_cnt_d = alloc_cnt_q - 1'b1;
						end
					end
					CMD_WIRE: begin
						if (ps_rd == PS_ALLOC) begin
							meta_we     = 1'b1;
							meta_wdata  = {PS_WIRED, WC_ONE};
							alloc_cnt_d = alloc_cnt_q - 1'b1;
							wired_cnt_d = wired_cnt_q + 1'b1;
						end else if (ps_rd == PS_WIRED) begin
							if (wc_rd == WC_MAX) begin
								status_d = STS_WIRE_FULL;
							end else begin
								meta_we    = 1'b1;
								meta_wdata = {PS_WIRED, WCB'(wc_rd + WC_ONE)};
							end
						end else begin
							status_d = STS_IS_FREE;
						end
					end
					CMD_UNWIRE: begin
						if (ps_rd != PS_WIRED || wc_rd == '0) begin
							status_d = STS_NOT_WIRED;
						end else begin
							meta_we = 1'b1;
							if (wc_dec == '0) begin
								meta_wdata  = {PS_ALLOC, {WCB{1'b0}}};
								wired_cnt_d = wired_cnt_q - 1'b1;
								alloc_cnt_d = alloc_cnt_q + 1'b1;
							end else begin
								meta_wdata = {PS_WIRED, wc_dec};
							end
						end
					end
					default: begin
						status_d = STS_OK;
					end
				endcase
			end

			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			free_cnt_q  <= '0;
			wired_cnt_q <= '0;
			alloc_cnt_q <= '0;
			done_q      <= 1'b0;
			sweep_q     <= '0;
		end else begin
			state_q     <= state_d;
			head_q      <= head_d;
			tail_q      <= tail_d;
			free_cnt_q  <= free_cnt_d;
			wired_cnt_q <= wired_cnt_d;
			alloc_cnt_q <= alloc_cnt_d;
			done_q      <= done_d;
			if (accept) begin
				sweep_q <= '0;
			end else if (state_q == ST_SWEEP) begin
				sweep_q <= AW'(sweep_q + 1'b1);
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			pg_q  <= page_index;
		end
		status_q <= status_d;
		given_q  <= given_d;
	end

	// per-page state and wire count
	pfa_ram #(
		.WIDTH(MW),
		.DEPTH(NUM_PAGES)
	) u_meta_ram (
		.clk  (clk),
		.we   (meta_we),
		.waddr(meta_waddr),
		.wdata(meta_wdata),
		.raddr(meta_raddr),
		.rdata(meta_rdata)
	);

	// free list ring
	pfa_ram #(
		.WIDTH(AW),
		.DEPTH(NUM_PAGES)
	) u_ring_ram (
		.clk  (clk),
		.we   (ring_we),
		.waddr(ring_waddr),
		.wdata(ring_wdata),
		.raddr(head_q),
		.rdata(ring_rdata)
	);

	assign done            = done_q;
	assign status          = status_q;
	assign allocated_page  = FIELD_W'(given_q);
	assign free_pages      = COUNT_W'(free_cnt_q);
	assign wired_pages     = COUNT_W'(wired_cnt_q);
	assign allocated_pages = COUNT_W'(alloc_cnt_q);

endmodule

`default_nettype wire

// ----- rtl/pfa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- rtl/pfa_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module pfa_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [2:0]  status,
	input wire logic [pfa_pkg::FIELD_W-1:0] allocated_page
);

	import pfa_pkg::*;

	// a taken command always occupies the block for at least the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low right after a command transfer");

	// a result only closes a period of work
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without preceding work");

	// no two results in consecutive cycles
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_status_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == STS_OK || status == STS_NO_FREE || status == STS_IS_FREE
			|| status == STS_IS_WIRED || status == STS_NOT_WIRED
			|| status == STS_WIRE_FULL))
		else $error("status code out of range");

	// a page number is only handed out by a successful command
	a_page_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STS_OK) |-> (allocated_page == '0))
		else $error("page number reported with an error status");

endmodule

bind page_frame_allocator_unit pfa_checker u_pfa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.allocated_page(allocated_page)
);

`default_nettype wire
